@@ rtl/core/fsm_pkg.sv @@
// Shared types, codes and constants of the stack machine core.
`default_nettype none
package fsm_pkg;
  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned DATA_DEPTH_DEF = 1024;
  localparam int unsigned DW = 64;
  localparam int unsigned OPW = 4;
  localparam int unsigned STW = 3;
  localparam int unsigned DEPW = 8;

  typedef enum logic [OPW-1:0] {
    OP_LIT = 4'd0, OP_DUP = 4'd1, OP_DROP = 4'd2, OP_SWAP = 4'd3, OP_OVER = 4'd4,
    OP_ROT = 4'd5, OP_ADD = 4'd6, OP_SUB = 4'd7, OP_MUL = 4'd8, OP_DIV = 4'd9,
    OP_MOD = 4'd10, OP_FETCH = 4'd11, OP_STORE = 4'd12
  } op_t;

  typedef enum logic [STW-1:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZ = 3'd3, ST_ADDR = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_MUL, S_DIV, S_DIVFIX,
    S_MEMRD, S_MEMWAIT, S_WB1, S_WB2, S_WB3, S_TOPRD, S_OUT
  } state_t;
endpackage
`default_nettype wire

@@ rtl/core/fsm_word_if.sv @@
// Valid/ready channel interface with a generic payload.
`default_nettype none
interface fsm_word_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fsm_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module fsm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/core/fsm_alu.sv @@
// Shared arithmetic unit: add, subtract (also used for the divide steps) and 16x64 multiply step.
`default_nettype none
module fsm_alu (
  input  wire logic [fsm_pkg::DW-1:0] a,
  input  wire logic [fsm_pkg::DW-1:0] b,
  input  wire logic [15:0]            mdig,
  input  wire logic [1:0]             mode,
  output logic      [fsm_pkg::DW-1:0] y,
  output logic                        carry
);
  import fsm_pkg::*;
  logic [DW:0] sum;
  logic [DW+15:0] prod;
  always_comb begin
    sum = '0;
    prod = '0;
    carry = 1'b0;
    case (mode)
      2'd0: begin
        sum = {1'b0, a} + {1'b0, b};
        y = sum[DW-1:0];
      end
      2'd1: begin
        sum = {1'b0, a} - {1'b0, b};
        y = sum[DW-1:0];
        carry = sum[DW];
      end
      2'd2: begin
        prod = {16'd0, b} * {{DW{1'b0}}, mdig};
        y = a + prod[DW-1:0];
      end
      default: y = a;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/core/forth_stack_machine_executor_core.sv @@
// Top level of the stack machine core: sequencer, stack and data memory.
//
// Input channel in_ carries one word: operation and literal_value. Result
// channel out_ returns one result per word: status, top_value, stack_depth.
// The block takes one word at a time; in_ready is high only when idle.
// Steps from accept to out_valid: three stack RAM reads through one RAM port,
// execute, one write-back, top read and output register for lit, dup, over,
// add and sub; swap has two write-backs and rot three, while drop, unused
// opcodes and refused words have none. Mul adds four 16-bit steps of one
// multiplier, div and mod add one quotient bit a cycle on a shared subtractor
// then the sign fix-up, and fetch and store add a data memory access and its
// wait. in_ready rises the cycle after the result is loaded. After reset the
// data memory is swept to zero, one entry a cycle, while in_ready stays low.
// The stack pointer resets to 0. A result waits in an output register while
// out_ready is low; the next word is still taken, but the core holds before
// loading the next result until the waiting one is taken.
`default_nettype none
module forth_stack_machine_executor_core #(
  parameter int unsigned STACK_DEPTH = fsm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DATA_DEPTH = fsm_pkg::DATA_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  fsm_word_if.sink in_word,
  fsm_word_if.source out_word
);
  import fsm_pkg::*;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  state_t state_r, state_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [OPW-1:0] op_r, op_nxt;
  logic [DW-1:0] lit_r, lit_nxt, t_r, t_nxt, s_r, s_nxt, a_r, a_nxt;
  logic [DW-1:0] res_r, res_nxt, q_r, q_nxt, rem_r, rem_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  status_t st_r, st_nxt;
  logic [DAW:0] clr_r, clr_nxt;
  logic [DW-1:0] otop_r, otop_nxt;
  status_t ost_r, ost_nxt;
  logic [DEPW-1:0] odep_r, odep_nxt;
  logic ovalid_r, ovalid_nxt;

  logic s_we;
  logic [SAW-1:0] s_addr;
  logic [DW-1:0] s_wdata, s_rdata;
  logic d_we;
  logic [DAW-1:0] d_addr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic [DW-1:0] alu_a, alu_b, alu_y;
  logic [15:0] alu_d;
  logic [1:0] alu_m;
  logic alu_c;
  logic [1:0] need;
  logic push, addr_ok;
  logic [DW-1:0] ma, mb, remsh;

  fsm_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
  fsm_ram #(.WIDTH(DW), .DEPTH(DATA_DEPTH)) u_data (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata));
  fsm_alu u_alu (.a(alu_a), .b(alu_b), .mdig(alu_d), .mode(alu_m), .y(alu_y),
    .carry(alu_c));

  always_comb begin
    need = 2'd0;
    push = 1'b0;
    case (op_r)
      OP_LIT: push = 1'b1;
      OP_DUP: begin need = 2'd1; push = 1'b1; end
      OP_DROP, OP_FETCH: need = 2'd1;
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_STORE: need = 2'd2;
      OP_OVER: begin need = 2'd2; push = 1'b1; end
      OP_ROT: need = 2'd3;
      default: need = 2'd0;
    endcase
    addr_ok = !t_r[DW-1] && ({1'b0, t_r} < (DW+1)'(DATA_DEPTH));
    ma = s_r[DW-1] ? -s_r : s_r;
    mb = t_r[DW-1] ? -t_r : t_r;
    remsh = {rem_r[DW-2:0], q_r[DW-1]};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == (DAW+1)'(DATA_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_word.valid) state_nxt = S_RD1;
      S_RD1: state_nxt = S_RD2;
      S_RD2: state_nxt = S_RD3;
      S_RD3: state_nxt = S_EXEC;
      S_EXEC: begin
        if (sp_r < SPW'(need) || (push && !(sp_r + 1'b1 < SPW'(STACK_DEPTH))))
          state_nxt = S_TOPRD;
        else begin
          case (op_r)
            OP_MUL: state_nxt = S_MUL;
            OP_DIV, OP_MOD: state_nxt = (t_r == '0) ? S_TOPRD : S_DIV;
            OP_FETCH, OP_STORE: state_nxt = addr_ok ? S_MEMRD : S_TOPRD;
            OP_DROP: state_nxt = S_TOPRD;
            OP_LIT, OP_DUP, OP_OVER, OP_SWAP, OP_ROT, OP_ADD, OP_SUB:
              state_nxt = S_WB1;
            default: state_nxt = S_TOPRD;
          endcase
        end
      end
      S_MUL: if (cnt_r == 7'd3) state_nxt = S_WB1;
      S_DIV: if (cnt_r == 7'd63) state_nxt = S_DIVFIX;
      S_DIVFIX: state_nxt = S_WB1;
      S_MEMRD: state_nxt = S_MEMWAIT;
      S_MEMWAIT: state_nxt = (op_r == OP_FETCH) ? S_WB1 : S_TOPRD;
      S_WB1: state_nxt = (op_r == OP_SWAP || op_r == OP_ROT) ? S_WB2 : S_TOPRD;
      S_WB2: state_nxt = (op_r == OP_ROT) ? S_WB3 : S_TOPRD;
      S_WB3: state_nxt = S_TOPRD;
      S_TOPRD: state_nxt = S_OUT;
      S_OUT: if (!ovalid_r || out_word.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sp_nxt = sp_r; op_nxt = op_r; lit_nxt = lit_r; t_nxt = t_r; s_nxt = s_r;
    a_nxt = a_r; res_nxt = res_r; q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    st_nxt = st_r; clr_nxt = clr_r; otop_nxt = otop_r; ost_nxt = ost_r;
    odep_nxt = odep_r;
    ovalid_nxt = ovalid_r && !out_word.ready;
    s_we = 1'b0; s_addr = SAW'(sp_r); s_wdata = res_r;
    d_we = 1'b0; d_addr = DAW'(t_r); d_wdata = s_r;
    alu_a = s_r; alu_b = t_r; alu_d = '0; alu_m = 2'd3;
    in_word.ready = (state_r == S_IDLE);
    case (state_r)
      S_CLEAR: begin
        d_we = 1'b1; d_addr = DAW'(clr_r); d_wdata = '0;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        op_nxt = in_word.data.operation; lit_nxt = in_word.data.literal_value;
        st_nxt = ST_OK; cnt_nxt = '0;
      end
      S_RD1: begin s_addr = SAW'(sp_r - 1'b1); t_nxt = s_rdata; end
      S_RD2: begin s_addr = SAW'(sp_r - 2'd2); s_nxt = s_rdata; end
      S_RD3: a_nxt = s_rdata;
      S_EXEC: begin
        if (sp_r < SPW'(need)) st_nxt = ST_UNDER;
        else if (push && !(sp_r + 1'b1 < SPW'(STACK_DEPTH))) st_nxt = ST_OVER;
        else begin
          case (op_r)
            OP_LIT: res_nxt = lit_r;
            OP_DUP: res_nxt = t_r;
            OP_OVER: res_nxt = s_r;
            OP_DROP: sp_nxt = sp_r - 1'b1;
            OP_SWAP, OP_ROT: res_nxt = s_r;
            OP_ADD: begin alu_m = 2'd0; res_nxt = alu_y; end
            OP_SUB: begin alu_m = 2'd1; res_nxt = alu_y; end
            OP_MUL: res_nxt = '0;
            OP_DIV, OP_MOD: begin
              if (t_r == '0) st_nxt = ST_DIVZ;
              q_nxt = ma; rem_nxt = '0;
            end
            OP_FETCH, OP_STORE: if (!addr_ok) st_nxt = ST_ADDR;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        alu_m = 2'd2; alu_a = res_r;
        alu_b = s_r << (cnt_r[1:0] * 16);
        alu_d = t_r[cnt_r[1:0]*16 +: 16];
        res_nxt = alu_y; cnt_nxt = cnt_r + 1'b1;
      end
      S_DIV: begin
        alu_m = 2'd1; alu_a = remsh; alu_b = mb;
        if (rem_r[DW-1] || !alu_c) begin
          rem_nxt = alu_y; q_nxt = {q_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = remsh; q_nxt = {q_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_DIVFIX: begin
        if (op_r == OP_DIV) res_nxt = (s_r[DW-1] ^ t_r[DW-1]) ? -q_r : q_r;
        else res_nxt = s_r[DW-1] ? -rem_r : rem_r;
      end
      S_MEMRD: if (op_r == OP_STORE) d_we = 1'b1;
      S_MEMWAIT: begin
        res_nxt = d_rdata;
        if (op_r == OP_STORE) sp_nxt = sp_r - 2'd2;
      end
      S_WB1: begin
        s_we = 1'b1;
        case (op_r)
          OP_LIT, OP_DUP, OP_OVER: begin
            s_addr = SAW'(sp_r + 1'b1); sp_nxt = sp_r + 1'b1;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            s_addr = SAW'(sp_r - 1'b1); sp_nxt = sp_r - 1'b1;
          end
          OP_SWAP, OP_FETCH: s_addr = SAW'(sp_r);
          OP_ROT: s_addr = SAW'(sp_r - 2'd2);
          default: s_we = 1'b0;
        endcase
      end
      S_WB2: begin
        s_we = 1'b1; s_addr = SAW'(sp_r - 1'b1); s_wdata = t_r;
      end
      S_WB3: begin
        s_we = 1'b1; s_addr = SAW'(sp_r); s_wdata = a_r;
      end
      S_TOPRD: s_addr = SAW'(sp_r);
      S_OUT: begin
        if (!ovalid_r || out_word.ready) begin
          ovalid_nxt = 1'b1; ost_nxt = st_r; odep_nxt = DEPW'(sp_r);
          otop_nxt = (sp_r != '0) ? s_rdata : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; sp_r <= '0; clr_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; sp_r <= sp_nxt; clr_r <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; lit_r <= lit_nxt; t_r <= t_nxt; s_r <= s_nxt; a_r <= a_nxt;
    res_r <= res_nxt; q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    st_r <= st_nxt; otop_r <= otop_nxt; ost_r <= ost_nxt; odep_r <= odep_nxt;
  end

  assign out_word.valid = ovalid_r;
  assign out_word.data.status = ost_r;
  assign out_word.data.top_value = otop_r;
  assign out_word.data.stack_depth = odep_r;
endmodule
`default_nettype wire

@@ rtl/core/fsm_checker.sv @@
// Port-level checker for the stack machine core, bound to the top level.
`default_nettype none
module fsm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_depth
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd4) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_depth))
    else $error("result dropped");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("reset state");
endmodule

bind forth_stack_machine_executor_core fsm_checker u_fsm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_word.valid), .in_ready(in_word.ready),
  .out_valid(out_word.valid), .out_ready(out_word.ready),
  .out_status(out_word.data.status), .out_depth(out_word.data.stack_depth));
`default_nettype wire
